// File: src/plep_pkg.sv
// plep_pkg: shared types and constants of the pin listener poll engine
// holds the table entry layout, request codes, sequencer states and slot compare structs
// depends on nothing
package plep_pkg;

	localparam int LISTENER_SLOTS_DEF = 32;
	localparam int MAX_REPORTS = 32;
	localparam int REP_W = $clog2(MAX_REPORTS + 1);
	localparam int PIN_W = 6;
	localparam int NUM_PINS = 64;
	localparam int EXP_W = 3;
	localparam int TICK_LSB_W = 7;

	localparam logic KIND_DIGITAL = 1'b0;
	localparam logic KIND_ANALOG = 1'b1;

	typedef enum logic [1:0] {
		REQ_SET = 2'd0,
		REQ_TICK = 2'd1,
		REQ_CLEAR = 2'd2
	} plep_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SETWR,
		ST_FLUSH
	} plep_state_t;

	// one table word: pin plus listener settings
	typedef struct packed {
		logic [PIN_W-1:0] pin;
		logic active;
		logic analog;
		logic level;
		logic is_local;
		logic [EXP_W-1:0] exponent;
	} plep_entry_t;

	// request side of the slot compare unit
	typedef struct packed {
		logic is_tick;
		logic [PIN_W-1:0] pin;
		logic [TICK_LSB_W-1:0] tick_lsb;
		logic [NUM_PINS-1:0] levels;
	} plep_eval_req_t;

	// result of comparing one slot against the current request
	typedef struct packed {
		logic pin_hit;
		logic free;
		logic report;
		logic kind;
		logic level;
	} plep_eval_t;

endpackage

// File: src/plep_slot_eval.sv
// plep_slot_eval: compare unit shared by every slot visit of a set or a tick
// pin match and free-slot test for set, due test and level change for tick
// depends on plep_pkg
module plep_slot_eval (
	input  plep_pkg::plep_entry_t    entry,
	input  plep_pkg::plep_eval_req_t req,
	output plep_pkg::plep_eval_t     res
);

	logic [plep_pkg::TICK_LSB_W-1:0] mask;
	logic due;
	logic lv;

	always_comb begin
		mask = plep_pkg::TICK_LSB_W'((8'd1 << entry.exponent) - 8'd1);
		due = entry.active && ((req.tick_lsb & mask) == '0);
		lv = req.levels[entry.pin];

		res = '0;
		if (req.is_tick) begin
			if (due && entry.analog) begin
				res.report = 1'b1;
				res.kind = plep_pkg::KIND_ANALOG;
				res.level = 1'b0;
			end else if (due && (lv != entry.level)) begin
				res.report = 1'b1;
				res.kind = plep_pkg::KIND_DIGITAL;
				res.level = lv;
			end
		end else begin
			res.pin_hit = (entry.pin == req.pin);
			res.free = !entry.active;
		end
	end

endmodule

// File: src/pin_listener_poll_engine_unit.sv
// pin_listener_poll_engine_unit: top level of the pin listener poll engine
// listener table in a memory, slot sequencer, report buffer and output register
// depends on plep_pkg and plep_slot_eval
//
// channel  dir  tdata                                        tuser         tlast
// s_axis   in   pin, enable, is_analog, rate_exponent,       req_type      -
//               from_local, tick_count, pin_levels
// m_axis   out  report_pin, new_level                        report_kind   last_report
//
// a set or tick transaction visits slots one per cycle through the slot compare unit, unless the scan stalls;
// a set stops early on the first slot holding its pin, a tick on reaching MAX_REPORTS reports
// then a set passes through the write state and a tick through the flush state, back to idle
// a clear transaction or an unknown request type is taken in the idle state with no scan
// reset empties the table at once through per-slot valid flags; no clearing pass
// a tick stalls its slot scan while a report waits and the output register is full;
// s_axis_tready is high only while the sequencer is idle
module pin_listener_poll_engine_unit #(
	parameter int LISTENER_SLOTS = plep_pkg::LISTENER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pin[5:0], enable[6], is_analog[7], rate_exponent[10:8], from_local[11],
	// tick_count[27:12], pin_levels[91:28], zero fill [95:92]
	input  logic [95:0] s_axis_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// report_pin[5:0], new_level[6], zero fill [7]
	output logic [7:0]  m_axis_tdata,
	// report_kind[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int IDX_W = (LISTENER_SLOTS > 1) ? $clog2(LISTENER_SLOTS) : 1;
	localparam int CNT_W = $clog2(LISTENER_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(LISTENER_SLOTS);
	localparam logic [plep_pkg::REP_W-1:0] REP_CAP = plep_pkg::REP_W'(plep_pkg::MAX_REPORTS);

	// sequencer
	plep_pkg::plep_state_t state_q, state_d;

	// request held for the length of a scan
	logic                              req_tick_q;
	logic [plep_pkg::PIN_W-1:0]        req_pin_q;
	logic                              req_enable_q;
	logic                              req_analog_q;
	logic [plep_pkg::EXP_W-1:0]        req_exp_q;
	logic                              req_local_q;
	logic [plep_pkg::TICK_LSB_W-1:0]   req_tick_lsb_q;
	logic [plep_pkg::NUM_PINS-1:0]     req_levels_q;

	// listener table and per-slot flags
	plep_pkg::plep_entry_t             mem [LISTENER_SLOTS];
	logic [LISTENER_SLOTS-1:0]         ent_vld_q;
	logic [LISTENER_SLOTS-1:0]         loc_q;

	// slot scan
	logic [CNT_W-1:0]                  rd_cnt_q;
	logic                              s1_vld_q;
	logic [IDX_W-1:0]                  s1_idx_q;
	plep_pkg::plep_entry_t             rd_data_s1;
	plep_pkg::plep_entry_t             entry_s1;
	plep_pkg::plep_eval_req_t          ev_req;
	plep_pkg::plep_eval_t              ev;

	// set search results
	logic                              hit_q;
	logic [IDX_W-1:0]                  hit_idx_q;
	logic                              hit_loc_q;
	logic                              free_q;
	logic [IDX_W-1:0]                  free_idx_q;

	// report buffer: one report held back until it is known whether it is the last
	logic [plep_pkg::REP_W-1:0]        rep_cnt_q;
	logic                              pend_vld_q;
	logic [plep_pkg::PIN_W-1:0]        pend_pin_q;
	logic                              pend_kind_q;
	logic                              pend_lvl_q;

	// output register
	logic                              out_vld_q;
	logic [plep_pkg::PIN_W-1:0]        out_pin_q;
	logic                              out_kind_q;
	logic                              out_lvl_q;
	logic                              out_last_q;

	// control
	logic                              in_acc;
	plep_pkg::plep_req_t               in_req;
	logic                              out_free;
	logic                              cap_hit;
	logic                              stall;
	logic                              set_hit;
	logic                              scan_end;
	logic                              issue;
	logic                              eval_go;
	logic                              push_pend;
	logic                              push_last;
	logic                              mem_we;
	logic [IDX_W-1:0]                  mem_waddr;
	plep_pkg::plep_entry_t             mem_wdata;
	plep_pkg::plep_entry_t             set_word;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_req = plep_pkg::plep_req_t'(s_axis_tuser);
	assign out_free = !out_vld_q || m_axis_tready;

	// a slot that was never written or was wiped reads as all zero
	assign entry_s1 = ent_vld_q[s1_idx_q] ? rd_data_s1 : '0;

	assign ev_req.is_tick = req_tick_q;
	assign ev_req.pin = req_pin_q;
	assign ev_req.tick_lsb = req_tick_lsb_q;
	assign ev_req.levels = req_levels_q;

	plep_slot_eval u_eval (
		.entry (entry_s1),
		.req   (ev_req),
		.res   (ev)
	);

	// scan control terms
	assign cap_hit = (state_q == plep_pkg::ST_SCAN) && req_tick_q && (rep_cnt_q == REP_CAP);
	assign stall = (state_q == plep_pkg::ST_SCAN) && s1_vld_q && req_tick_q && ev.report
		&& pend_vld_q && !out_free;
	assign set_hit = (state_q == plep_pkg::ST_SCAN) && s1_vld_q && !req_tick_q && ev.pin_hit;
	assign scan_end = !s1_vld_q && (rd_cnt_q == SLOT_END);
	assign issue = (state_q == plep_pkg::ST_SCAN) && !stall && !cap_hit && !set_hit
		&& (rd_cnt_q < SLOT_END);
	assign eval_go = (state_q == plep_pkg::ST_SCAN) && s1_vld_q && !stall && !cap_hit;

	always_comb begin
		set_word.pin = req_pin_q;
		set_word.active = req_enable_q;
		set_word.analog = req_analog_q;
		set_word.level = 1'b0;
		set_word.is_local = req_local_q;
		set_word.exponent = req_exp_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			plep_pkg::ST_IDLE: begin
				if (in_acc && ((in_req == plep_pkg::REQ_SET) || (in_req == plep_pkg::REQ_TICK)))
					state_d = plep_pkg::ST_SCAN;
			end
			plep_pkg::ST_SCAN: begin
				if (cap_hit)
					state_d = plep_pkg::ST_FLUSH;
				else if (set_hit)
					state_d = plep_pkg::ST_SETWR;
				else if (scan_end)
					state_d = req_tick_q ? plep_pkg::ST_FLUSH : plep_pkg::ST_SETWR;
			end
			plep_pkg::ST_SETWR: begin
				state_d = plep_pkg::ST_IDLE;
			end
			plep_pkg::ST_FLUSH: begin
				if (!pend_vld_q || out_free)
					state_d = plep_pkg::ST_IDLE;
			end
			default: begin
				state_d = plep_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we = 1'b0;
		mem_waddr = s1_idx_q;
		mem_wdata = entry_s1;
		push_pend = 1'b0;
		push_last = 1'b0;
		case (state_q)
			plep_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			plep_pkg::ST_SCAN: begin
				// a digital report stores the new level back into its slot
				if (eval_go && req_tick_q && ev.report) begin
					push_pend = pend_vld_q;
					if (ev.kind == plep_pkg::KIND_DIGITAL) begin
						mem_we = 1'b1;
						mem_wdata.level = ev.level;
					end
				end
			end
			plep_pkg::ST_SETWR: begin
				// a local slot only takes a local request; no match takes the lowest free slot
				mem_wdata = set_word;
				if (hit_q) begin
					mem_we = !hit_loc_q || req_local_q;
					mem_waddr = hit_idx_q;
				end else begin
					mem_we = free_q;
					mem_waddr = free_idx_q;
				end
			end
			plep_pkg::ST_FLUSH: begin
				push_last = pend_vld_q && out_free;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= plep_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_pin_q <= s_axis_tdata[5:0];
			req_enable_q <= s_axis_tdata[6];
			req_analog_q <= s_axis_tdata[7];
			req_exp_q <= s_axis_tdata[10:8];
			req_local_q <= s_axis_tdata[11];
			req_tick_lsb_q <= s_axis_tdata[18:12];
			req_levels_q <= s_axis_tdata[91:28];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_tick_q <= 1'b0;
		else if (in_acc)
			req_tick_q <= (in_req == plep_pkg::REQ_TICK);
	end

	// table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (issue)
			rd_data_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

	// slot flags: clear drops every non-local slot back to the empty value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			loc_q <= '0;
		end else if (in_acc && (in_req == plep_pkg::REQ_CLEAR)) begin
			ent_vld_q <= ent_vld_q & loc_q;
		end else if (mem_we) begin
			ent_vld_q[mem_waddr] <= 1'b1;
			loc_q[mem_waddr] <= mem_wdata.is_local;
		end
	end

	// scan counter and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			s1_vld_q <= 1'b0;
			s1_idx_q <= '0;
		end else begin
			if (in_acc)
				rd_cnt_q <= '0;
			else if (issue)
				rd_cnt_q <= rd_cnt_q + 1'b1;
			if (!stall)
				s1_vld_q <= issue;
			if (issue)
				s1_idx_q <= rd_cnt_q[IDX_W-1:0];
		end
	end

	// set search: first slot with the pin, lowest inactive slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			hit_loc_q <= 1'b0;
			free_q <= 1'b0;
			free_idx_q <= '0;
		end else if (in_acc) begin
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (eval_go && !req_tick_q) begin
			if (ev.pin_hit) begin
				hit_q <= 1'b1;
				hit_idx_q <= s1_idx_q;
				hit_loc_q <= entry_s1.is_local;
			end
			if (ev.free && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= s1_idx_q;
			end
		end
	end

	// report count and held-back report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_cnt_q <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (in_acc)
				rep_cnt_q <= '0;
			else if (eval_go && req_tick_q && ev.report)
				rep_cnt_q <= rep_cnt_q + 1'b1;
			if (eval_go && req_tick_q && ev.report)
				pend_vld_q <= 1'b1;
			else if (push_last)
				pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go && req_tick_q && ev.report) begin
			pend_pin_q <= entry_s1.pin;
			pend_kind_q <= ev.kind;
			pend_lvl_q <= ev.level;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (push_pend || push_last)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push_pend || push_last) begin
			out_pin_q <= pend_pin_q;
			out_kind_q <= pend_kind_q;
			out_lvl_q <= pend_lvl_q;
			out_last_q <= push_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {1'b0, out_lvl_q, out_pin_q};
	assign m_axis_tuser = out_kind_q;
	assign m_axis_tlast = out_last_q;

endmodule

// File: bench/pin_listener_poll_engine_unit_test.sv
// pin_listener_poll_engine_unit_test: self-checking bench for the pin listener poll engine
// keeps a shadow listener table, predicts the report stream per request and checks m_axis
// depends on plep_pkg and pin_listener_poll_engine_unit
module pin_listener_poll_engine_unit_test;

	localparam int SLOTS = plep_pkg::LISTENER_SLOTS_DEF;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 400;
	localparam int TIMEOUT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
	// idle phases and the long receiver hold-off, keyed on accepted transactions
	localparam int PHASE_SWAP = 140;
	localparam int PHASE_CALM = 280;
	localparam int HOLD_AT = 320;
	localparam int HOLD_CYCLES = 300;
	// request code the block must ignore
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// one request as the sender sees it
	typedef struct packed {
		logic [1:0] req;
		logic [63:0] levels;
		logic [15:0] tick;
		logic from_local;
		logic [plep_pkg::EXP_W-1:0] rate_exp;
		logic is_analog;
		logic enable;
		logic [plep_pkg::PIN_W-1:0] pin;
	} listen_req_t;

	// one report as it leaves m_axis
	typedef struct packed {
		logic [plep_pkg::PIN_W-1:0] pin;
		logic kind;
		logic level;
		logic last;
	} pin_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	listen_req_t req_feed_q[$];     // requests not yet offered
	pin_report_t report_q[$];       // reports predicted but not yet seen
	plep_pkg::plep_entry_t shadow_tab[SLOTS] = '{default: '0};
	listen_req_t drv_item = '0;     // request currently on s_axis
	logic in_acc = 1'b0;            // s_axis transaction at the last rising edge
	int in_count = 0;
	int mismatch_cnt = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	pin_listener_poll_engine_unit #(
		.LISTENER_SLOTS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------- request builders

	function automatic listen_req_t set_req(input int pin, input bit en, input bit analog,
			input int rate_exp, input bit loc);
		listen_req_t r;
		r.req = plep_pkg::REQ_SET;
		r.pin = plep_pkg::PIN_W'(pin);
		r.enable = en;
		r.is_analog = analog;
		r.rate_exp = plep_pkg::EXP_W'(rate_exp);
		r.from_local = loc;
		// don't-care fields for a set, kept random so their bits toggle
		r.tick = 16'($urandom);
		r.levels = {$urandom, $urandom};
		return r;
	endfunction

	function automatic listen_req_t tick_req(input logic [15:0] tick, input logic [63:0] levels);
		listen_req_t r;
		r = set_req($urandom_range(63), 1'($urandom_range(1)), 1'($urandom_range(1)),
			$urandom_range(7), 1'($urandom_range(1)));
		r.req = plep_pkg::REQ_TICK;
		r.tick = tick;
		r.levels = levels;
		return r;
	endfunction

	function automatic listen_req_t bare_req(input logic [1:0] code);
		listen_req_t r;
		r = tick_req(16'($urandom), {$urandom, $urandom});
		r.req = code;
		return r;
	endfunction

	// tick numbers with many low zero bits reach the slow dividers too
	function automatic logic [15:0] rand_tick();
		if ($urandom_range(1))
			return 16'($urandom);
		return 16'($urandom) << $urandom_range(7);
	endfunction

	// ---------------------------------------------------------------- listener table predictor

	// applies one accepted request to the shadow table and queues the reports it causes
	task automatic poll_table_apply(input listen_req_t r);
		int i;
		int hit;
		int n;
		logic lv;
		logic [15:0] mask;
		plep_pkg::plep_entry_t fresh;
		pin_report_t rep;
		fresh = '0;
		fresh.active = r.enable;
		fresh.analog = r.is_analog;
		fresh.is_local = r.from_local;
		fresh.exponent = r.rate_exp;
		fresh.pin = r.pin;
		case (r.req)
			plep_pkg::REQ_SET: begin
				// first slot with the pin wins, active or not
				hit = -1;
				for (i = 0; i < SLOTS; i++)
					if (hit < 0 && shadow_tab[i].pin == r.pin)
						hit = i;
				if (hit >= 0) begin
					// a local slot only takes a local rewrite; the request is consumed anyway
					if (!shadow_tab[hit].is_local || r.from_local)
						shadow_tab[hit] = fresh;
				end else begin
					// lowest inactive slot, or dropped when the table is full
					for (i = 0; i < SLOTS; i++)
						if (hit < 0 && !shadow_tab[i].active)
							hit = i;
					if (hit >= 0)
						shadow_tab[hit] = fresh;
				end
			end
			plep_pkg::REQ_TICK: begin
				n = 0;
				for (i = 0; i < SLOTS && n < plep_pkg::MAX_REPORTS; i++) begin
					mask = (16'd1 << shadow_tab[i].exponent) - 16'd1;
					if (shadow_tab[i].active && (r.tick & mask) == 16'd0) begin
						rep = '0;
						rep.pin = shadow_tab[i].pin;
						if (shadow_tab[i].analog) begin
							rep.kind = plep_pkg::KIND_ANALOG;
							report_q.push_back(rep);
							n++;
						end else begin
							lv = r.levels[shadow_tab[i].pin];
							if (lv != shadow_tab[i].level) begin
								shadow_tab[i].level = lv;
								rep.kind = plep_pkg::KIND_DIGITAL;
								rep.level = lv;
								report_q.push_back(rep);
								n++;
							end
						end
					end
				end
				if (n > 0)
					report_q[report_q.size() - 1].last = 1'b1;
			end
			plep_pkg::REQ_CLEAR: begin
				for (i = 0; i < SLOTS; i++)
					if (!shadow_tab[i].is_local)
						shadow_tab[i] = '0;
			end
			default: begin
				// unknown request: no state change, no report
			end
		endcase
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatch_cnt++;
		end
	endtask

	// ---------------------------------------------------------------- sender

	// a new transaction is offered once the previous one went through
	always @(negedge clk) begin : sender
		listen_req_t nxt;
		int gap_pct;
		gap_pct = (in_count < PHASE_SWAP) ? 13 : (in_count < PHASE_CALM) ? 72 : 0;
		if (arst_n && (!s_axis_tvalid || in_acc)) begin
			if (req_feed_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				nxt = req_feed_q.pop_front();
				s_axis_tdata <= {4'b0, nxt.levels, nxt.tick, nxt.from_local, nxt.rate_exp,
					nxt.is_analog, nxt.enable, nxt.pin};
				s_axis_tuser <= nxt.req;
				drv_item <= nxt;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// random back pressure, plus one long hold-off that lets the engine fill up
	always @(negedge clk) begin
		int stall_pct;
		stall_pct = (in_count < PHASE_SWAP) ? 72 : (in_count < PHASE_CALM) ? 13 : 0;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && in_count >= HOLD_AT) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : observe
		pin_report_t want;
		pin_report_t got;
		in_acc <= arst_n && s_axis_tvalid && s_axis_tready;
		// predict at acceptance so the shadow table follows the engine's order
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			poll_table_apply(drv_item);
			in_count <= in_count + 1;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pin = m_axis_tdata[plep_pkg::PIN_W-1:0];
			got.level = m_axis_tdata[plep_pkg::PIN_W];
			got.kind = m_axis_tuser;
			got.last = m_axis_tlast;
			if (report_q.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual pin %0d kind %0d",
					$time, got.pin, got.kind);
				mismatch_cnt++;
			end else begin
				want = report_q.pop_front();
				check_field("report_pin", 8'(want.pin), 8'(got.pin));
				check_field("report_kind", 8'(want.kind), 8'(got.kind));
				check_field("new_level", 8'(want.level), 8'(got.level));
				check_field("last_report", 8'(want.last), 8'(got.last));
			end
		end
	end

	// ---------------------------------------------------------------- stimulus and end of run

	initial begin
		int n_rand;
		int pick;
		int k;
		int j;
		listen_req_t r;

		// directed part
		// pin 0 lands in slot 0, which holds pin 0 while inactive after reset
		req_feed_q.push_back(set_req(0, 1'b1, 1'b0, 0, 1'b0));
		req_feed_q.push_back(set_req(63, 1'b1, 1'b1, 7, 1'b1));
		req_feed_q.push_back(tick_req(16'h0000, '1));
		// remote rewrite of a local slot is swallowed
		req_feed_q.push_back(set_req(63, 1'b0, 1'b0, 0, 1'b0));
		// rewrite drops the stored level back to zero
		req_feed_q.push_back(set_req(0, 1'b1, 1'b0, 1, 1'b0));
		req_feed_q.push_back(tick_req(16'hFFFF, '1));
		req_feed_q.push_back(tick_req(16'h0002, '1));
		req_feed_q.push_back(set_req(5, 1'b1, 1'b1, 0, 1'b1));
		req_feed_q.push_back(set_req(17, 1'b0, 1'b0, 3, 1'b0));
		req_feed_q.push_back(tick_req(16'h0080, '0));
		req_feed_q.push_back(bare_req(REQ_UNKNOWN));
		// inactive slot with a matching pin is reused
		req_feed_q.push_back(set_req(0, 1'b0, 1'b0, 0, 1'b0));
		req_feed_q.push_back(set_req(0, 1'b1, 1'b0, 0, 1'b1));
		req_feed_q.push_back(set_req(40, 1'b1, 1'b0, 2, 1'b0));
		req_feed_q.push_back(set_req(41, 1'b1, 1'b1, 0, 1'b0));
		req_feed_q.push_back(tick_req(16'h0000, 64'h5555_5555_5555_5555));
		req_feed_q.push_back(tick_req(16'h0004, 64'hAAAA_AAAA_AAAA_AAAA));
		req_feed_q.push_back(bare_req(plep_pkg::REQ_CLEAR));
		req_feed_q.push_back(tick_req(16'h0000, '0));
		req_feed_q.push_back(tick_req(16'h0000, '1));

		// random part: mostly bursts of sets followed by ticks, some clears and noise
		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				k = $urandom_range(1, 6);
				for (j = 0; j < k; j++)
					req_feed_q.push_back(set_req($urandom_range(63), $urandom_range(99) < 85,
						1'($urandom_range(1)), $urandom_range(7), $urandom_range(99) < 25));
				n_rand += k;
				k = $urandom_range(1, 4);
				for (j = 0; j < k; j++)
					req_feed_q.push_back(tick_req(rand_tick(), {$urandom, $urandom}));
				n_rand += k;
			end else if (pick < 90) begin
				req_feed_q.push_back(tick_req(rand_tick(), {$urandom, $urandom}));
				n_rand++;
			end else if (pick < 94) begin
				req_feed_q.push_back(bare_req(plep_pkg::REQ_CLEAR));
				n_rand++;
			end else if (pick < 97) begin
				req_feed_q.push_back(bare_req(REQ_UNKNOWN));
				n_rand++;
			end else begin
				// disabled listener on a random pin
				r = set_req($urandom_range(63), 1'b0, 1'($urandom_range(1)), $urandom_range(7),
					1'($urandom_range(1)));
				req_feed_q.push_back(r);
				n_rand++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all requests offered and taken, then every predicted report seen
		while (req_feed_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (report_q.size() != 0)
			@(posedge clk);
		// room for any surplus report to show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(2 * HALF_PERIOD * TIMEOUT_CYCLES);
		$display("%0t: timeout", $time);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
